// File: rtl/multi_button_short_long_press_macros.svh
// Assertion macros for the short/long button press detector.
// Included by the files that carry concurrent assertions; no other dependency.
`ifndef MULTI_BUTTON_SHORT_LONG_PRESS_MACROS_SVH
`define MULTI_BUTTON_SHORT_LONG_PRESS_MACROS_SVH

// same-cycle implication, checked out of reset
`define MBSLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MBSLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mbslp_pkg.sv
// Package for the short/long button press detector: sizes, codes, types.
// No dependencies; used by the channel interfaces and the top level.
package mbslp_pkg;

    localparam int NUM_BUTTONS  = 4;
    localparam int TIME_BITS    = 32;
    localparam int BTN_W        = 2;
    localparam int CODE_W       = 6;
    localparam int TABLE_W      = NUM_BUTTONS * CODE_W;
    localparam int MS_W         = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    localparam logic [MS_W-1:0]        LONG_PRESS_RST = MS_W'(1000);
    localparam logic [MS_W-1:0]        MIN_PRESS_RST  = MS_W'(10);
    localparam logic [BTN_W-1:0]       MENU_DOWN_RST  = BTN_W'(0);
    localparam logic [BTN_W-1:0]       MENU_UP_RST    = BTN_W'(1);

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_LONG  = 2'd2;

    localparam logic [1:0] FORCE_SHORT = 2'd1;
    localparam logic [1:0] FORCE_LONG  = 2'd2;

    localparam logic [2:0] MENU_NONE    = 3'd0;
    localparam logic [2:0] MENU_NEXT    = 3'd1;
    localparam logic [2:0] MENU_PREV    = 3'd2;
    localparam logic [2:0] MENU_SELECT  = 3'd3;
    localparam logic [2:0] MENU_REFRESH = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS,
        CFG_MIN_PRESS,
        CFG_REPEAT_MASK,
        CFG_SHORT_TABLE,
        CFG_LONG_TABLE,
        CFG_MENU_DOWN,
        CFG_MENU_UP
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_BITS-1:0] start_time;
        logic                 last_level;
        logic                 fire_enabled;
    } t_entry;

    typedef struct packed {
        logic [BTN_W-1:0]     button_index;
        logic                 level;
        logic [1:0]           forced_result;
        logic [TIME_BITS-1:0] now_ms;
        logic                 menu_mode;
    } t_item;

    function automatic logic [CODE_W-1:0] table_code(input logic [TABLE_W-1:0] tbl,
                                                     input logic [BTN_W-1:0] b);
        return tbl[CODE_W*b +: CODE_W];
    endfunction

endpackage

// File: rtl/mbslp_ifs.sv
// Valid/ready channel interfaces for the button press detector:
// sample input, press result output and register write. Uses mbslp_pkg.
interface mbslp_in_if;
    import mbslp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [BTN_W-1:0]     button_index;
    logic                 level;
    logic [1:0]           forced_result;
    logic [TIME_BITS-1:0] now_ms;
    logic                 menu_mode;
    modport source (output valid, button_index, level, forced_result, now_ms, menu_mode,
                    input ready);
    modport sink (input valid, button_index, level, forced_result, now_ms, menu_mode,
                  output ready);
endinterface

interface mbslp_out_if;
    import mbslp_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        press_kind;
    logic [CODE_W-1:0] action_code;
    logic              to_menu;
    logic [2:0]        menu_command;
    modport source (output valid, press_kind, action_code, to_menu, menu_command,
                    input ready);
    modport sink (input valid, press_kind, action_code, to_menu, menu_command,
                  output ready);
endinterface

interface mbslp_cfg_if;
    import mbslp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/multi_button_short_long_press.sv
// Short/long press detector for four buttons, per-button state in a small RAM.
// Depends on mbslp_pkg, the channel interfaces in mbslp_ifs.sv and the macro header.
//
// Channels: i_in takes one button sample per item (button, level, forced
// result, millisecond time, menu mode). o_out gives exactly one result item
// per sample, in order: press kind, table action code or menu command.
// i_cfg writes the seven registers by index; it is always ready, and should
// only be written while no sample is in flight.
// Path: a sample is registered with its state RAM read into stage 1, then
// into the result register on o_out. Throughput: one sample per cycle while
// o_out is not stalled, set by the read-modify-write of the state RAM, with
// forwarding of the write data when the next sample hits the same button.
// Reset: registers return to their defaults and the per-button valid bits
// clear, so every button reads as start time 0, pressed, firing disabled.
// No clearing pass is needed.
// Stall: while o_out is held, the result register and the RAM stage hold and
// i_in.ready drops once both are full; nothing is dropped or repeated.
module multi_button_short_long_press (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbslp_in_if.sink     i_in,
    mbslp_out_if.source  o_out,
    mbslp_cfg_if.sink    i_cfg
);
    import mbslp_pkg::*;

    logic [MS_W-1:0]        r_long_press_ms;
    logic [MS_W-1:0]        r_min_press_ms;
    logic [NUM_BUTTONS-1:0] r_repeat_mask;
    logic [TABLE_W-1:0]     r_short_table;
    logic [TABLE_W-1:0]     r_long_table;
    logic [BTN_W-1:0]       r_menu_down;
    logic [BTN_W-1:0]       r_menu_up;

    t_entry                 r_mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_vld;

    logic                   r_s1_valid;
    t_item                  r_s1;
    t_entry                 r_rd;

    logic                   r_out_valid;
    logic [1:0]             r_out_kind;
    logic [CODE_W-1:0]      r_out_code;
    logic                   r_out_menu;
    logic [2:0]             r_out_cmd;

    logic                   s1_adv;
    logic                   in_ready;
    logic                   in_acc;
    logic                   wr_en;
    logic                   upd;
    t_entry                 n_ent;
    logic [1:0]             n_kind;
    logic [CODE_W-1:0]      n_code;
    logic                   n_menu;
    logic [2:0]             n_cmd;
    logic [TIME_BITS-1:0]   held;
    logic                   rep;
    logic                   held_gt_long;
    logic                   held_lt_long;
    logic                   held_gt_min;

    assign s1_adv   = !r_out_valid || o_out.ready;
    assign in_ready = !r_s1_valid || s1_adv;
    assign in_acc   = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_out_valid;
    assign o_out.press_kind   = r_out_kind;
    assign o_out.action_code  = r_out_code;
    assign o_out.to_menu      = r_out_menu;
    assign o_out.menu_command = r_out_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms <= LONG_PRESS_RST;
            r_min_press_ms  <= MIN_PRESS_RST;
            r_repeat_mask   <= '0;
            r_short_table   <= '0;
            r_long_table    <= '0;
            r_menu_down     <= MENU_DOWN_RST;
            r_menu_up       <= MENU_UP_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_LONG_PRESS:  r_long_press_ms <= i_cfg.data[MS_W-1:0];
                CFG_MIN_PRESS:   r_min_press_ms  <= i_cfg.data[MS_W-1:0];
                CFG_REPEAT_MASK: r_repeat_mask   <= i_cfg.data[NUM_BUTTONS-1:0];
                CFG_SHORT_TABLE: r_short_table   <= i_cfg.data[TABLE_W-1:0];
                CFG_LONG_TABLE:  r_long_table    <= i_cfg.data[TABLE_W-1:0];
                CFG_MENU_DOWN:   r_menu_down     <= i_cfg.data[BTN_W-1:0];
                CFG_MENU_UP:     r_menu_up       <= i_cfg.data[BTN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        held         = r_s1.now_ms - r_rd.start_time;
        rep          = r_repeat_mask[r_s1.button_index];
        held_gt_long = held > TIME_BITS'(r_long_press_ms);
        held_lt_long = held < TIME_BITS'(r_long_press_ms);
        held_gt_min  = held > TIME_BITS'(r_min_press_ms);
        n_ent        = r_rd;
        n_kind       = KIND_NONE;
        upd          = 1'b0;
        if (r_s1.forced_result == FORCE_SHORT || r_s1.forced_result == FORCE_LONG) begin
            n_kind = r_s1.forced_result;
        end else begin
            upd = 1'b1;
            if (!r_s1.level) begin
                if (r_rd.last_level) begin
                    n_ent.start_time = r_s1.now_ms;
                end else if (held_gt_long && (r_rd.fire_enabled || rep)) begin
                    n_ent.fire_enabled = 1'b0;
                    n_kind = KIND_LONG;
                end
            end else if (!r_rd.last_level && held_gt_min && held_lt_long
                         && r_rd.fire_enabled) begin
                n_ent.fire_enabled = 1'b0;
                n_kind = KIND_SHORT;
            end else begin
                n_ent.fire_enabled = 1'b1;
            end
            n_ent.last_level = r_s1.level;
        end

        n_code = '0;
        n_menu = 1'b0;
        n_cmd  = MENU_NONE;
        if (n_kind != KIND_NONE) begin
            if (r_s1.menu_mode) begin
                n_menu = 1'b1;
                if (n_kind == KIND_LONG) begin
                    n_cmd = MENU_SELECT;
                end else if (r_s1.button_index == r_menu_down) begin
                    n_cmd = MENU_NEXT;
                end else if (r_s1.button_index == r_menu_up) begin
                    n_cmd = MENU_PREV;
                end else begin
                    n_cmd = MENU_REFRESH;
                end
            end else begin
                n_code = table_code((n_kind == KIND_LONG) ? r_long_table : r_short_table,
                                    r_s1.button_index);
            end
        end
    end

    assign wr_en = r_s1_valid && s1_adv && upd;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1.button_index] <= n_ent;
        end
        if (in_acc) begin
            r_s1.button_index  <= i_in.button_index;
            r_s1.level         <= i_in.level;
            r_s1.forced_result <= i_in.forced_result;
            r_s1.now_ms        <= i_in.now_ms;
            r_s1.menu_mode     <= i_in.menu_mode;
            if (wr_en && r_s1.button_index == i_in.button_index) begin
                r_rd <= n_ent;
            end else if (r_vld[i_in.button_index]) begin
                r_rd <= r_mem[i_in.button_index];
            end else begin
                r_rd <= '0;
            end
        end
        if (s1_adv && r_s1_valid) begin
            r_out_kind <= n_kind;
            r_out_code <= n_code;
            r_out_menu <= n_menu;
            r_out_cmd  <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[r_s1.button_index] <= 1'b1;
            end
            if (in_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

`include "multi_button_short_long_press_macros.svh"

    `MBSLP_ASSERT_NOW(a_none_is_blank, i_clk, i_rst_n, r_out_valid && r_out_kind == KIND_NONE, r_out_code == '0 && !r_out_menu && r_out_cmd == MENU_NONE, "press-free result carries data")
    `MBSLP_ASSERT_NOW(a_menu_has_cmd, i_clk, i_rst_n, r_out_valid && r_out_menu, r_out_code == '0 && r_out_cmd != MENU_NONE, "menu result malformed")
    `MBSLP_ASSERT_NOW(a_forced_no_write, i_clk, i_rst_n, r_s1_valid && (r_s1.forced_result == FORCE_SHORT || r_s1.forced_result == FORCE_LONG), !wr_en, "forced sample wrote state")
    `MBSLP_ASSERT_NEXT(a_write_sets_valid, i_clk, i_rst_n, wr_en, r_vld[$past(r_s1.button_index)], "written entry not marked valid")
    `MBSLP_ASSERT_NEXT(a_stall_holds_result, i_clk, i_rst_n, r_out_valid && !o_out.ready, r_out_valid && $stable(r_out_kind) && $stable(r_out_cmd), "stalled result changed")

endmodule
